FILE: src/erld_pkg.sv
// ----------------------------------------------------------------------------
// erld_pkg
// Shared types and constants for the escape-byte run-length decoder.
// ----------------------------------------------------------------------------
package erld_pkg;

   localparam int LENGTH_BITS    = 24;
   localparam int COUNT_BITS     = LENGTH_BITS + 1;
   localparam int BYTE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (LENGTH_BITS > BYTE_BITS) ? LENGTH_BITS : BYTE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ESCAPE_BYTE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_LENGTH = CSR_INDEX_BITS'(1);

   typedef enum logic [1:0] {
      PH_LITERAL = 2'd0,
      PH_VALUE   = 2'd1,
      PH_COUNT   = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0]   escape_byte;
      logic [LENGTH_BITS-1:0] output_length;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [BYTE_BITS-1:0] in_byte;
      logic                 block_start;
   } in_item_type;

endpackage

FILE: src/escape_rle_decoder.sv
// ----------------------------------------------------------------------------
// escape_rle_decoder
// Escape-byte run-length decoder: one compressed byte in, at most one run out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the compressed stream one byte per transaction; req_tuser
//   set on a byte clears phase, held value and decoded count before it.
//   rsp_* carries one decoded run per transaction: value, length, and
//   rsp_tlast when the decoded count has reached output_length.
//   csr_* writes escape_byte (index 0) or output_length (index 1); the user
//   must write only while the decoder is idle, which the block does not enforce; other indexes are ignored.
// Timing:
//   An accepted byte passes an input register, then the decode logic loads
//   the result register, which drives rsp_tvalid once a run is decoded. One
//   byte is taken every cycle unless a waiting run stalls the output; the rate
//   is set by the single decode step between the two registers.
// Reset: empties both registers, clears phase and count, and zeroes both
//   configuration registers.
// Stall: while rsp_tready is low and a run is waiting, the input register
//   holds one more byte, then req_tready drops until the run is taken.
// ----------------------------------------------------------------------------
module escape_rle_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [erld_pkg::BYTE_BITS-1:0]        req_tdata,  // [7:0] in_byte
   input  logic                                  req_tuser,  // [0] block_start
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [2*erld_pkg::BYTE_BITS-1:0]      rsp_tdata,  // [7:0] run_value, [15:8] run_length
   output logic                                  rsp_tlast,  // block_done
   input  logic                                  csr_wr_en,
   input  logic [erld_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [erld_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   erld_pkg::cfg_type     cfg_ff, cfg_in;
   erld_pkg::in_item_type item;
   logic                  take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            erld_pkg::CSR_ESCAPE_BYTE:
               cfg_in.escape_byte = csr_wdata[erld_pkg::BYTE_BITS-1:0];
            erld_pkg::CSR_OUTPUT_LENGTH:
               cfg_in.output_length = csr_wdata[erld_pkg::LENGTH_BITS-1:0];
            default: begin
               // unmapped index: ignore
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   erld_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item       (item)
   );

   erld_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/erld_in_stage.sv
// ----------------------------------------------------------------------------
// erld_in_stage
// Input register: captures one stream byte and its start flag per transaction.
// ----------------------------------------------------------------------------
module erld_in_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [erld_pkg::BYTE_BITS-1:0]  req_tdata,   // [7:0] in_byte
   input  logic                            req_tuser,   // [0] block_start
   input  logic                            take,
   output erld_pkg::in_item_type           item
);

   logic                           valid_ff, valid_in;
   logic [erld_pkg::BYTE_BITS-1:0] byte_ff, byte_in;
   logic                           start_ff, start_in;
   logic                           accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      start_in = start_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
         start_in = req_tuser;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff  <= byte_in;
      start_ff <= start_in;
   end

   assign item.valid       = valid_ff;
   assign item.in_byte     = byte_ff;
   assign item.block_start = start_ff;

endmodule

FILE: src/erld_decode.sv
// ----------------------------------------------------------------------------
// erld_decode
// Phase tracking, run counting and the result register.
// ----------------------------------------------------------------------------
module erld_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  erld_pkg::cfg_type                 cfg,
   input  erld_pkg::in_item_type             item,
   output logic                              take,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*erld_pkg::BYTE_BITS-1:0]  rsp_tdata,  // [7:0] run_value, [15:8] run_length
   output logic                              rsp_tlast   // block_done
);

   localparam int CB = erld_pkg::COUNT_BITS;
   localparam int BB = erld_pkg::BYTE_BITS;

   erld_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [BB-1:0]       held_ff, held_in, held_cur;
   logic [CB-1:0]       count_ff, count_in, count_cur, count_sat;
   logic [CB:0]         count_sum;
   logic [BB-1:0]       add_n;
   logic                reached;

   logic                res_valid;
   logic [BB-1:0]       res_value, res_length;

   logic                out_valid_ff, out_valid_in;
   logic [BB-1:0]       out_value_ff, out_value_in;
   logic [BB-1:0]       out_length_ff, out_length_in;
   logic                out_done_ff, out_done_in;

   assign take = item.valid && (!out_valid_ff || rsp_tready);

   // start flag clears the block state ahead of this byte
   assign phase_cur = item.block_start ? erld_pkg::PH_LITERAL : phase_ff;
   assign held_cur  = item.block_start ? '0 : held_ff;
   assign count_cur = item.block_start ? '0 : count_ff;

   assign add_n     = (phase_cur == erld_pkg::PH_LITERAL) ? BB'(1) : item.in_byte;
   assign count_sum = {1'b0, count_cur} + {{(CB+1-BB){1'b0}}, add_n};
   assign count_sat = count_sum[CB] ? '1 : count_sum[CB-1:0];
   assign reached   = count_sat >= {1'b0, cfg.output_length};

   always_comb begin
      phase_in   = phase_cur;
      held_in    = held_cur;
      count_in   = count_cur;
      res_valid  = 1'b0;
      res_value  = item.in_byte;
      res_length = BB'(1);
      unique case (phase_cur)
         erld_pkg::PH_LITERAL: begin
            if (item.in_byte == cfg.escape_byte) begin
               phase_in = erld_pkg::PH_VALUE;
            end else begin
               count_in  = count_sat;
               phase_in  = reached ? erld_pkg::PH_DONE : erld_pkg::PH_LITERAL;
               res_valid = 1'b1;
            end
         end
         erld_pkg::PH_VALUE: begin
            held_in  = item.in_byte;
            phase_in = erld_pkg::PH_COUNT;
         end
         erld_pkg::PH_COUNT: begin
            count_in   = count_sat;
            phase_in   = reached ? erld_pkg::PH_DONE : erld_pkg::PH_LITERAL;
            res_valid  = item.in_byte != '0;
            res_value  = held_cur;
            res_length = item.in_byte;
         end
         default: begin
            // block ended: drop bytes until the next start
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_length_in = out_length_ff;
      out_done_in   = out_done_ff;
      if (take) begin
         out_valid_in  = res_valid;
         out_value_in  = res_value;
         out_length_in = res_length;
         out_done_in   = reached;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= erld_pkg::PH_LITERAL;
         held_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
            count_ff <= count_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_length_ff <= out_length_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_length_ff, out_value_ff};
   assign rsp_tlast  = out_done_ff;

   // a delivered run never has zero length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_length_ff != '0)
      else $error("run with zero length in result register");

   // a run that ends the block leaves the decoder in the ended phase
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      (take && res_valid && reached) |=> phase_ff == erld_pkg::PH_DONE)
      else $error("block_done set but phase not ended");

   // the ended phase persists until a start flag
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (take && phase_ff == erld_pkg::PH_DONE && !item.block_start)
      |=> phase_ff == erld_pkg::PH_DONE)
      else $error("left ended phase without block start");

   // count never decreases within a block
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (take && !item.block_start) |=> count_ff >= $past(count_ff))
      else $error("decoded count decreased within a block");

endmodule
